/* sv/tfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_pkg
// shared field widths of the triangle flattening core
// ----------------------------------------------------------------------------
package tfp_pkg;

    // result field widths, fixed by the output format
    localparam int EDGE_W   = 34;
    localparam int APEX_X_W = 35;
    localparam int APEX_Y_W = 34;
    localparam int OUT_BITS = EDGE_W + APEX_X_W + APEX_Y_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [EDGE_W-1:0]          t_edge;
    typedef logic signed [APEX_X_W-1:0] t_apex_x;
    typedef logic [APEX_Y_W-1:0]        t_apex_y;

endpackage

/* sv/tfp_sqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_sqrt_pipe
// pipelined floored integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module tfp_sqrt_pipe #(
    parameter int NW = 68,
    parameter int PW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_n,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [NW/2-1:0]   o_root,
    output logic [PW-1:0]     o_pay
);
    localparam int RW = NW / 2;

    logic          r_v    [RW];
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [NW-1:0] r_n    [RW];
    logic [PW-1:0] r_pay  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          c_v;
        logic [RW+1:0] c_rem;
        logic [RW-1:0] c_root;
        logic [NW-1:0] c_n;
        logic [PW-1:0] c_pay;
        logic [RW+1:0] t_acc;
        logic [RW+1:0] t_try;
        logic [RW+1:0] n_rem;
        logic [RW-1:0] n_root;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_n    = i_n;
            assign c_pay  = i_pay;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_n    = r_n[k-1];
            assign c_pay  = r_pay[k-1];
        end

        // bring down the next two radicand bits, try root bit one
        always_comb begin
            t_acc = {c_rem[RW-1:0], c_n[NW-1-2*k -: 2]};
            t_try = {c_root, 2'b01};
            if (t_acc >= t_try) begin
                n_rem  = t_acc - t_try;
                n_root = {c_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = t_acc;
                n_root = {c_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_n[k]    <= c_n;
                r_pay[k]  <= c_pay;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_pay   = r_pay[RW-1];

endmodule

/* sv/tfp_div_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tfp_div_pipe #(
    parameter int NW = 68,
    parameter int DW = 34,
    parameter int QW = 35,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);
    // quotient is known to fit in QW bits, so the top of the numerator
    // starts out below the divisor
    logic          r_v   [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW];
    logic [PW-1:0] r_pay [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          c_v;
        logic [DW-1:0] c_rem;
        logic [QW-1:0] c_quo;
        logic [QW-1:0] c_low;
        logic [DW-1:0] c_den;
        logic [PW-1:0] c_pay;
        logic [DW:0]   t_acc;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_rem = {{(DW+QW-NW){1'b0}}, i_num[NW-1:QW]};
            assign c_quo = '0;
            assign c_low = i_num[QW-1:0];
            assign c_den = i_den;
            assign c_pay = i_pay;
        end else begin : g_next
            assign c_v   = r_v[k-1];
            assign c_rem = r_rem[k-1];
            assign c_quo = r_quo[k-1];
            assign c_low = r_low[k-1];
            assign c_den = r_den[k-1];
            assign c_pay = r_pay[k-1];
        end

        always_comb begin
            t_acc = {c_rem, c_low[QW-1-k]};
            n_quo = c_quo;
            if (t_acc >= {1'b0, c_den}) begin
                n_rem           = DW'(t_acc - {1'b0, c_den});
                n_quo[QW-1-k]   = 1'b1;
            end else begin
                n_rem = t_acc[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_low[k] <= c_low;
                r_den[k] <= c_den;
                r_pay[k] <= c_pay;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

/* sv/triangle_flatten_to_plane_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_flatten_to_plane_core
// lays a 3d triangle flat in the plane, keeping its edge lengths
// ----------------------------------------------------------------------------
// One triangle beat in, one result beat out, a new triangle every cycle while
// the output side takes results. A triangle passes stages 1 to 4, the edge
// square-root pipeline, the divider, stages 5 and 6, the apex square-root
// pipeline and the output register; the three pipelines are bit-per-stage. The
// whole pipeline freezes while a result waits at the output, so nothing is
// lost or repeated. Vertex a maps to the origin, b to (edge_length, 0) and c
// to (apex_x, apex_y); all values are raw fixed point, so the fraction width
// does not change any result bit. When b equals a, degenerate is set and all
// three result values are zero.
module triangle_flatten_to_plane_core #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero padded
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // edge_length, apex_x, apex_y from bit 0 up, zero padded
    output logic [tfp_pkg::OUT_W-1:0]                 m_axis_tdata,
    // degenerate
    output logic [0:0]                                m_axis_tuser
);
    import tfp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int M  = W + 1;        // difference magnitude
    localparam int LW = 2 * M + 2;    // sum of three squares
    localparam int RW = M + 1;        // root width
    localparam int QW = M + 2;        // quotient width
    // raw integers throughout; fraction width leaves the datapath unchanged
    localparam int FB = FRAC_BITS;

    logic en;
    logic r_ov;

    // whole pipeline advances unless a result sits unaccepted
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 1: edge vectors as sign and magnitude
    logic         r1_v;
    logic [M-1:0] r1_m1 [3];
    logic [M-1:0] r1_m2 [3];
    logic [2:0]   r1_xs;

    for (genvar i = 0; i < 3; i++) begin : g_diff
        logic signed [M-1:0] d1;
        logic signed [M-1:0] d2;
        logic signed [W-1:0] ca;
        logic signed [W-1:0] cb;
        logic signed [W-1:0] cc;
        assign ca = s_axis_tdata[i*W +: W];
        assign cb = s_axis_tdata[(3+i)*W +: W];
        assign cc = s_axis_tdata[(6+i)*W +: W];
        assign d1 = M'(cb) - M'(ca);
        assign d2 = M'(cc) - M'(ca);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_m1[i] <= d1[M-1] ? M'(-d1) : M'(d1);
                r1_m2[i] <= d2[M-1] ? M'(-d2) : M'(d2);
                r1_xs[i] <= d1[M-1] ^ d2[M-1];
            end
        end
    end

    // ---- stage 2: nine products
    logic           r2_v;
    logic [2*M-1:0] r2_p11 [3];
    logic [2*M-1:0] r2_p22 [3];
    logic [2*M-1:0] r2_p12 [3];
    logic [2:0]     r2_xs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_p11[i] <= r1_m1[i] * r1_m1[i];
                r2_p22[i] <= r1_m2[i] * r1_m2[i];
                r2_p12[i] <= r1_m1[i] * r1_m2[i];
            end
            r2_xs <= r1_xs;
        end
    end

    // ---- stage 3: squared lengths and split dot product
    logic          r3_v;
    logic [LW-1:0] r3_len1, r3_len2, r3_pos, r3_neg;
    logic [LW-1:0] n3_pos, n3_neg;

    always_comb begin
        n3_pos = '0;
        n3_neg = '0;
        for (int i = 0; i < 3; i++) begin
            if (r2_xs[i]) begin
                n3_neg = n3_neg + LW'(r2_p12[i]);
            end else begin
                n3_pos = n3_pos + LW'(r2_p12[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_len1 <= LW'(r2_p11[0]) + LW'(r2_p11[1]) + LW'(r2_p11[2]);
            r3_len2 <= LW'(r2_p22[0]) + LW'(r2_p22[1]) + LW'(r2_p22[2]);
            r3_pos  <= n3_pos;
            r3_neg  <= n3_neg;
        end
    end

    // ---- stage 4: dot magnitude and sign, zero edge detect
    logic          r4_v;
    logic [LW-1:0] r4_len1, r4_len2, r4_dot;
    logic          r4_dsign, r4_degen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_len1  <= r3_len1;
            r4_len2  <= r3_len2;
            r4_dsign <= r3_pos < r3_neg;
            r4_dot   <= (r3_pos < r3_neg) ? r3_neg - r3_pos : r3_pos - r3_neg;
            r4_degen <= r3_len1 == '0;
        end
    end

    // ---- edge length root
    localparam int P1 = 2 * LW + 2;
    logic          q1_v;
    logic [RW-1:0] q1_edge;
    logic [P1-1:0] q1_pay;

    tfp_sqrt_pipe #(.NW(LW), .PW(P1)) u_sqrt_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_n     (r4_len1),
        .i_pay   ({r4_len2, r4_dot, r4_dsign, r4_degen}),
        .o_valid (q1_v),
        .o_root  (q1_edge),
        .o_pay   (q1_pay)
    );

    // ---- apex x magnitude, dot over edge length
    localparam int P2 = RW + LW + 2;
    logic          q2_v;
    logic [QW-1:0] q2_quo;
    logic [P2-1:0] q2_pay;

    tfp_div_pipe #(.NW(LW), .DW(RW), .QW(QW), .PW(P2)) u_div_apex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q1_v),
        .i_num   (q1_pay[LW+1:2]),
        .i_den   (q1_edge),
        .i_pay   ({q1_edge, q1_pay[P1-1:LW+2], q1_pay[1:0]}),
        .o_valid (q2_v),
        .o_quo   (q2_quo),
        .o_pay   (q2_pay)
    );

    // ---- stage 5: square of apex x
    logic            r5_v;
    logic [2*QW-1:0] r5_sq;
    logic [QW-1:0]   r5_q;
    logic [P2-1:0]   r5_pay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sq  <= r5_q_in_sq(q2_quo);
            r5_q   <= q2_quo;
            r5_pay <= q2_pay;
        end
    end

    function automatic logic [2*QW-1:0] r5_q_in_sq(input logic [QW-1:0] q);
        return q * q;
    endfunction

    // ---- stage 6: clamped radicand and signed apex x
    logic                r6_v;
    logic [LW-1:0]       r6_rad;
    logic signed [QW:0]  r6_ax;
    logic [RW-1:0]       r6_edge;
    logic                r6_degen;
    logic [LW-1:0]       c6_len2;

    assign c6_len2 = r5_pay[LW+1:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rounding can leave apex x past the far edge: clamp to zero
            if ((2*QW)'(c6_len2) >= r5_sq) begin
                r6_rad <= c6_len2 - r5_sq[LW-1:0];
            end else begin
                r6_rad <= '0;
            end
            r6_ax    <= r5_pay[1] ? -$signed({1'b0, r5_q}) : $signed({1'b0, r5_q});
            r6_edge  <= r5_pay[P2-1:LW+2];
            r6_degen <= r5_pay[0];
        end
    end

    // ---- apex y root
    localparam int P3 = QW + 1 + RW + 1;
    logic          q3_v;
    logic [RW-1:0] q3_y;
    logic [P3-1:0] q3_pay;

    tfp_sqrt_pipe #(.NW(LW), .PW(P3)) u_sqrt_apex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_n     (r6_rad),
        .i_pay   ({r6_ax, r6_edge, r6_degen}),
        .o_valid (q3_v),
        .o_root  (q3_y),
        .o_pay   (q3_pay)
    );

    // ---- output register
    t_edge   r_o_edge;
    t_apex_x r_o_ax;
    t_apex_y r_o_ay;
    logic    r_o_degen;
    logic signed [QW:0] c_ax;

    assign c_ax = $signed(q3_pay[P3-1:RW+1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_degen <= q3_pay[0];
            if (q3_pay[0]) begin
                r_o_edge <= '0;
                r_o_ax   <= '0;
                r_o_ay   <= '0;
            end else begin
                r_o_edge <= EDGE_W'(q3_pay[RW:1]);
                r_o_ax   <= APEX_X_W'(c_ax);
                r_o_ay   <= APEX_Y_W'(q3_y);
            end
        end
    end

    // valid bits of the numbered stages and the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= q2_v;
            r6_v <= r5_v;
            r_ov <= q3_v;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, r_o_ay, r_o_ax, r_o_edge};
    assign m_axis_tuser  = r_o_degen;

    // fraction width carried for documentation of the format only
    logic unused_fb;
    assign unused_fb = FB[0];

endmodule
